// File: sv/hmtri_pkg.sv
// Shared types and constants for the heightmap triangle height query block.
`default_nettype none
package hmtri_pkg;

  // Item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING  = 2'd2;

  // Field widths
  localparam int DIM_W        = 8;   // grid_columns, grid_rows
  localparam int INV_W        = 24;  // inverse spacing, unsigned Q8.16
  localparam int POS_W        = 24;  // world position, signed Q15.8
  localparam int SAMPLE_IDX_W = 7;   // sample row / column
  localparam int OUT_W        = 24;  // terrain height, signed Q15.8

  // Internal datapath widths
  localparam int PROD_W  = 50;  // position times reciprocal, Q.24
  localparam int COORD_W = 35;  // cell coordinate, Q.8
  localparam int FRAC_W  = 36;  // in-cell fraction and its complement, Q.8

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0] COLUMNS_RST = 8'd128;
  localparam logic [DIM_W-1:0] ROWS_RST    = 8'd128;
  localparam logic [INV_W-1:0] INV_RST     = 24'd65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [FRAC_W-1:0]  frac_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage
`default_nettype wire

// File: sv/heightmap_triangle_height_query.sv
// Heightmap triangle height query: vertex height store plus interpolation pipeline.
//
// Input stream (in_*): in_tuser selects the kind of transaction. A write transaction stores
// sample_height at (sample_row, sample_column); it produces no output. A query transaction
// carries a world X/Z position and yields one terrain height on the output stream (out_*).
// Configuration (cfg_*): grid_columns, grid_rows and inverse_cell_spacing; write only while
// no transaction is in flight.
// Throughput: one transaction per cycle unless out_tready stalls the pipeline. The store is
// split into four banks by row and column parity, so the four corners of a cell are read in
// a single cycle. A query passes eight register stages (multiply, coordinate, clamp/address,
// bank read, triangle select, two multiplies, sum, saturate) before its result is presented
// on out_tvalid. A write lands in the store as it leaves the clamp/address stage; any later
// query sees it.
// Reset clears the pipeline valid bits and loads the configuration defaults; the store
// itself is not cleared, and reading an unwritten vertex returns undefined data.
// When out_tready is low the stages back up one by one; empty stages still fill, and
// in_tready falls only once every stage holds a transaction. Nothing is lost or repeated.
`default_nettype none
module heightmap_triangle_height_query #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 128,
  parameter int HEIGHT_BITS = 16,
  localparam int FIELDS_W = 2 * hmtri_pkg::SAMPLE_IDX_W + HEIGHT_BITS + 2 * hmtri_pkg::POS_W,
  localparam int IN_W     = ((FIELDS_W + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata, low bit up: sample_row, sample_column, sample_height, position_x,
  // position_z, zero padding
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [IN_W-1:0]                     in_tdata,
  input  wire logic                                in_tuser,   // opcode
  // out_tdata: terrain_height
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [hmtri_pkg::OUT_W-1:0]              out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [hmtri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hmtri_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int HB      = HEIGHT_BITS;
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int HROW_W  = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int HCOL_W  = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int BANK_AW = HROW_W + HCOL_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int IDX_W   = hmtri_pkg::SAMPLE_IDX_W;
  localparam int POS_W   = hmtri_pkg::POS_W;
  localparam int DIM_W   = hmtri_pkg::DIM_W;
  localparam int INV_W   = hmtri_pkg::INV_W;
  localparam int CW      = hmtri_pkg::COORD_W;
  localparam int TW      = hmtri_pkg::FRAC_W;
  localparam int PW      = HB + 1 + TW;
  localparam int SW      = HB + TW + 3;
  localparam int OUT_W   = hmtri_pkg::OUT_W;

  localparam int ROW_LSB = 0;
  localparam int COL_LSB = IDX_W;
  localparam int HGT_LSB = 2 * IDX_W;
  localparam int PX_LSB  = HGT_LSB + HB;
  localparam int PZ_LSB  = PX_LSB + POS_W;

  localparam hmtri_pkg::frac_t UNIT_Q8 = TW'(256);

  // ---------------------------------------------------------------- configuration
  logic [DIM_W-1:0] grid_columns_r;
  logic [DIM_W-1:0] grid_rows_r;
  logic [INV_W-1:0] inv_spacing_r;
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= hmtri_pkg::COLUMNS_RST;
      grid_rows_r    <= hmtri_pkg::ROWS_RST;
      inv_spacing_r  <= hmtri_pkg::INV_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hmtri_pkg::REG_GRID_COLUMNS: grid_columns_r <= cfg_data[DIM_W-1:0];
        hmtri_pkg::REG_GRID_ROWS:    grid_rows_r    <= cfg_data[DIM_W-1:0];
        hmtri_pkg::REG_INV_SPACING:  inv_spacing_r  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate grid size to [2, MAX]
  always_comb begin
    if (grid_columns_r < 8'd2) begin
      cols_eff = 8'd2;
    end else if (32'(grid_columns_r) > MAX_COLUMNS) begin
      cols_eff = DIM_W'(MAX_COLUMNS);
    end else begin
      cols_eff = grid_columns_r;
    end
    if (grid_rows_r < 8'd2) begin
      rows_eff = 8'd2;
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_r;
    end
  end

  // ---------------------------------------------------------------- stage control
  logic [8:1] valid_r;
  logic [8:1] stage_en;

  assign stage_en[8] = !valid_r[8] || out_tready;
  assign stage_en[7] = !valid_r[7] || stage_en[8];
  assign stage_en[6] = !valid_r[6] || stage_en[7];
  assign stage_en[5] = !valid_r[5] || stage_en[6];
  assign stage_en[4] = !valid_r[4] || stage_en[5];
  assign stage_en[3] = !valid_r[3] || stage_en[4];
  assign stage_en[2] = !valid_r[2] || stage_en[3];
  assign stage_en[1] = !valid_r[1] || stage_en[2];

  assign in_tready  = stage_en[1];
  assign out_tvalid = valid_r[8];

  logic s3_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[1]) valid_r[1] <= in_tvalid;
      if (stage_en[2]) valid_r[2] <= valid_r[1];
      if (stage_en[3]) valid_r[3] <= valid_r[2];
      // drop write transactions once they reach the store
      if (stage_en[4]) valid_r[4] <= valid_r[3] && (s3_op_r == hmtri_pkg::OP_QUERY);
      if (stage_en[5]) valid_r[5] <= valid_r[4];
      if (stage_en[6]) valid_r[6] <= valid_r[5];
      if (stage_en[7]) valid_r[7] <= valid_r[6];
      if (stage_en[8]) valid_r[8] <= valid_r[7];
    end
  end

  // ---------------------------------------------------------------- stage 1: multiply
  logic [IDX_W-1:0]         in_row;
  logic [IDX_W-1:0]         in_col;
  logic [ROW_W+IDX_W-1:0]   in_row_ext;
  logic [COL_W+IDX_W-1:0]   in_col_ext;
  logic signed [POS_W:0]    neg_pz;
  hmtri_pkg::prod_t         s1_prod_x_nxt;
  hmtri_pkg::prod_t         s1_prod_z_nxt;
  logic                     s1_wr_ok_nxt;

  always_comb begin
    in_row        = in_tdata[ROW_LSB +: IDX_W];
    in_col        = in_tdata[COL_LSB +: IDX_W];
    in_row_ext    = (ROW_W + IDX_W)'(in_row);
    in_col_ext    = (COL_W + IDX_W)'(in_col);
    s1_wr_ok_nxt  = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLUMNS);
    neg_pz        = -$signed({in_tdata[PZ_LSB+POS_W-1], in_tdata[PZ_LSB +: POS_W]});
    s1_prod_x_nxt = $signed({in_tdata[PX_LSB+POS_W-1], in_tdata[PX_LSB +: POS_W]})
                    * $signed({1'b0, inv_spacing_r});
    s1_prod_z_nxt = neg_pz * $signed({1'b0, inv_spacing_r});
  end

  logic               s1_op_r;
  logic               s1_wr_ok_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [HB-1:0]      s1_height_r;
  hmtri_pkg::prod_t   s1_prod_x_r;
  hmtri_pkg::prod_t   s1_prod_z_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_op_r     <= in_tuser;
      s1_wr_ok_r  <= s1_wr_ok_nxt;
      s1_row_r    <= in_row_ext[ROW_W-1:0];
      s1_col_r    <= in_col_ext[COL_W-1:0];
      s1_height_r <= in_tdata[HGT_LSB +: HB];
      s1_prod_x_r <= s1_prod_x_nxt;
      s1_prod_z_r <= s1_prod_z_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2: cell coordinate
  logic [DIM_W-1:0]  cols_m1;
  logic [DIM_W-1:0]  rows_m1;
  hmtri_pkg::coord_t s2_cx_nxt;
  hmtri_pkg::coord_t s2_cz_nxt;

  always_comb begin
    cols_m1   = cols_eff - 8'd1;
    rows_m1   = rows_eff - 8'd1;
    // grid center offset of (size-1)/2 cells, in Q.8
    s2_cx_nxt = $signed(CW'(s1_prod_x_r >>> 16)) + $signed(CW'({cols_m1, 7'b0}));
    s2_cz_nxt = $signed(CW'(s1_prod_z_r >>> 16)) + $signed(CW'({rows_m1, 7'b0}));
  end

  logic               s2_op_r;
  logic               s2_wr_ok_r;
  logic [ROW_W-1:0]   s2_row_r;
  logic [COL_W-1:0]   s2_col_r;
  logic [HB-1:0]      s2_height_r;
  hmtri_pkg::coord_t  s2_cx_r;
  hmtri_pkg::coord_t  s2_cz_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_op_r     <= s1_op_r;
      s2_wr_ok_r  <= s1_wr_ok_r;
      s2_row_r    <= s1_row_r;
      s2_col_r    <= s1_col_r;
      s2_height_r <= s1_height_r;
      s2_cx_r     <= s2_cx_nxt;
      s2_cz_r     <= s2_cz_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3: clamp cell
  hmtri_pkg::coord_t col_raw;
  hmtri_pkg::coord_t row_raw;
  hmtri_pkg::coord_t col_lim;
  hmtri_pkg::coord_t row_lim;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  s3_col_nxt;
  logic [ROW_W-1:0]  s3_row_nxt;

  always_comb begin
    col_raw = s2_cx_r >>> 8;
    row_raw = s2_cz_r >>> 8;
    col_lim = $signed(CW'(cols_eff - 8'd2));
    row_lim = $signed(CW'(rows_eff - 8'd2));
    if (col_raw[CW-1]) begin
      col_q = '0;
    end else if (col_raw > col_lim) begin
      col_q = COL_W'(col_lim);
    end else begin
      col_q = COL_W'(col_raw);
    end
    if (row_raw[CW-1]) begin
      row_q = '0;
    end else if (row_raw > row_lim) begin
      row_q = ROW_W'(row_lim);
    end else begin
      row_q = ROW_W'(row_raw);
    end
    // write transactions keep their sample address
    s3_col_nxt = (s2_op_r == hmtri_pkg::OP_QUERY) ? col_q : s2_col_r;
    s3_row_nxt = (s2_op_r == hmtri_pkg::OP_QUERY) ? row_q : s2_row_r;
  end

  logic               s3_wr_ok_r;
  logic [ROW_W-1:0]   s3_row_r;
  logic [COL_W-1:0]   s3_col_r;
  logic [HB-1:0]      s3_height_r;
  hmtri_pkg::coord_t  s3_cx_r;
  hmtri_pkg::coord_t  s3_cz_r;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_op_r     <= s2_op_r;
      s3_wr_ok_r  <= s2_wr_ok_r;
      s3_row_r    <= s3_row_nxt;
      s3_col_r    <= s3_col_nxt;
      s3_height_r <= s2_height_r;
      s3_cx_r     <= s2_cx_r;
      s3_cz_r     <= s2_cz_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: banked store
  // Bank {rp,cp} holds vertices whose row parity is rp and column parity is cp.
  // Even-parity banks take (idx+1)>>1, odd-parity banks take idx>>1, which covers
  // both idx and idx+1 with one read per bank.
  logic [ROW_W:0]        row_inc;
  logic [ROW_W:0]        row_ext;
  logic [COL_W:0]        col_inc;
  logic [COL_W:0]        col_ext;
  logic [HROW_W-1:0]     row_h0;
  logic [HROW_W-1:0]     row_h1;
  logic [HCOL_W-1:0]     col_h0;
  logic [HCOL_W-1:0]     col_h1;
  logic                  bank_wr;
  logic [3:0]            bank_we;
  logic [BANK_AW-1:0]    bank_addr [4];
  logic [HB-1:0]         bank_q [4];

  always_comb begin
    row_ext = (ROW_W + 1)'(s3_row_r);
    col_ext = (COL_W + 1)'(s3_col_r);
    row_inc = row_ext + 1'b1;
    col_inc = col_ext + 1'b1;
    row_h0  = row_inc[HROW_W:1];
    row_h1  = row_ext[HROW_W:1];
    col_h0  = col_inc[HCOL_W:1];
    col_h1  = col_ext[HCOL_W:1];
    // commit a write as it leaves this stage, in order with the queries around it
    bank_wr = valid_r[3] && stage_en[4] && (s3_op_r == hmtri_pkg::OP_WRITE) && s3_wr_ok_r;
  end

  for (genvar rp = 0; rp < 2; rp++) begin : g_bank_row
    for (genvar cp = 0; cp < 2; cp++) begin : g_bank_col
      assign bank_addr[rp*2+cp] = {(rp == 0) ? row_h0 : row_h1, (cp == 0) ? col_h0 : col_h1};
      assign bank_we[rp*2+cp]   = bank_wr && (s3_row_r[0] == 1'(rp)) && (s3_col_r[0] == 1'(cp));

      hmtri_ram #(
        .WIDTH (HB),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk     (clk),
        .wr_en   (bank_we[rp*2+cp]),
        .wr_addr (bank_addr[rp*2+cp]),
        .wr_data (s3_height_r),
        .rd_en   (stage_en[4]),
        .rd_addr (bank_addr[rp*2+cp]),
        .rd_data (bank_q[rp*2+cp])
      );
    end
  end

  hmtri_pkg::coord_t s4_dx_nxt;
  hmtri_pkg::coord_t s4_dz_nxt;

  always_comb begin
    s4_dx_nxt = s3_cx_r - $signed(CW'({s3_col_r, 8'h00}));
    s4_dz_nxt = s3_cz_r - $signed(CW'({s3_row_r, 8'h00}));
  end

  logic              s4_rpar_r;
  logic              s4_cpar_r;
  hmtri_pkg::coord_t s4_dx_r;
  hmtri_pkg::coord_t s4_dz_r;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_rpar_r <= s3_row_r[0];
      s4_cpar_r <= s3_col_r[0];
      s4_dx_r   <= s4_dx_nxt;
      s4_dz_r   <= s4_dz_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 5: triangle select
  logic signed [HB-1:0] ha;
  logic signed [HB-1:0] hb;
  logic signed [HB-1:0] hc;
  logic signed [HB-1:0] hd;
  logic signed [HB:0]   ha_e;
  logic signed [HB:0]   hb_e;
  logic signed [HB:0]   hc_e;
  logic signed [HB:0]   hd_e;
  hmtri_pkg::frac_t     dx_e;
  hmtri_pkg::frac_t     dz_e;
  hmtri_pkg::frac_t     frac_sum;
  logic                 upper;
  logic signed [HB-1:0] s5_base_nxt;
  logic signed [HB:0]   s5_d1_nxt;
  logic signed [HB:0]   s5_d2_nxt;
  hmtri_pkg::frac_t     s5_t1_nxt;
  hmtri_pkg::frac_t     s5_t2_nxt;

  always_comb begin
    ha       = $signed(bank_q[{s4_rpar_r, s4_cpar_r}]);
    hb       = $signed(bank_q[{s4_rpar_r, ~s4_cpar_r}]);
    hc       = $signed(bank_q[{~s4_rpar_r, s4_cpar_r}]);
    hd       = $signed(bank_q[{~s4_rpar_r, ~s4_cpar_r}]);
    ha_e     = (HB + 1)'(ha);
    hb_e     = (HB + 1)'(hb);
    hc_e     = (HB + 1)'(hc);
    hd_e     = (HB + 1)'(hd);
    dx_e     = TW'(s4_dx_r);
    dz_e     = TW'(s4_dz_r);
    frac_sum = dx_e + dz_e;
    upper    = frac_sum < UNIT_Q8;
    if (upper) begin
      // triangle ABC from corner A
      s5_base_nxt = ha;
      s5_d1_nxt   = hb_e - ha_e;
      s5_d2_nxt   = hc_e - ha_e;
      s5_t1_nxt   = dx_e;
      s5_t2_nxt   = dz_e;
    end else begin
      // triangle DCB from corner D
      s5_base_nxt = hd;
      s5_d1_nxt   = hc_e - hd_e;
      s5_d2_nxt   = hb_e - hd_e;
      s5_t1_nxt   = UNIT_Q8 - dx_e;
      s5_t2_nxt   = UNIT_Q8 - dz_e;
    end
  end

  logic signed [HB-1:0] s5_base_r;
  logic signed [HB:0]   s5_d1_r;
  logic signed [HB:0]   s5_d2_r;
  hmtri_pkg::frac_t     s5_t1_r;
  hmtri_pkg::frac_t     s5_t2_r;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_base_r <= s5_base_nxt;
      s5_d1_r   <= s5_d1_nxt;
      s5_d2_r   <= s5_d2_nxt;
      s5_t1_r   <= s5_t1_nxt;
      s5_t2_r   <= s5_t2_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 6: slope products
  logic signed [HB-1:0] s6_base_r;
  logic signed [PW-1:0] s6_p1_r;
  logic signed [PW-1:0] s6_p2_r;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s6_base_r <= s5_base_r;
      s6_p1_r   <= s5_d1_r * s5_t1_r;
      s6_p2_r   <= s5_d2_r * s5_t2_r;
    end
  end

  // ---------------------------------------------------------------- stage 7: sum
  logic signed [SW-1:0] s7_sum_nxt;
  logic signed [SW-1:0] s7_sum_r;

  always_comb begin
    s7_sum_nxt = (SW'(s6_base_r) <<< 8) + SW'(s6_p1_r) + SW'(s6_p2_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s7_sum_r <= s7_sum_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 8: saturate
  logic [SW-OUT_W:0]  sum_top;
  logic               in_range;
  logic [OUT_W-1:0]   out_nxt;
  logic [OUT_W-1:0]   out_tdata_r;

  always_comb begin
    sum_top  = s7_sum_r[SW-1:OUT_W-1];
    in_range = (&sum_top) || !(|sum_top);
    if (in_range) begin
      out_nxt = s7_sum_r[OUT_W-1:0];
    end else if (s7_sum_r[SW-1]) begin
      out_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      out_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      out_tdata_r <= out_nxt;
    end
  end

  assign out_tdata = out_tdata_r;

endmodule
`default_nettype wire

// File: sv/hmtri_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module hmtri_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the heightmap triangle height query block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX       = 128;
  localparam int IN_W           = 80;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 66;
  localparam int DIRECTED_STEPS = 25;
  localparam int IDX_W          = hmtri_pkg::SAMPLE_IDX_W;
  localparam int POS_W          = hmtri_pkg::POS_W;
  localparam int OUT_W          = hmtri_pkg::OUT_W;
  localparam int DIM_W          = hmtri_pkg::DIM_W;
  localparam int INV_W          = hmtri_pkg::INV_W;
  localparam int CFG_IDX_W      = hmtri_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = hmtri_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic [1:0] {STEP_WRITE, STEP_QUERY, STEP_CONFIG} step_kind_t;

  typedef struct {
    step_kind_t              kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        column;
    logic [15:0]             height;
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        pz;
    logic [CFG_IDX_W-1:0]    reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    bit                      typed;
    logic [OUT_W-1:0]        want;
  } directed_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire                   in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = hmtri_pkg::OP_WRITE;
  wire                   out_tvalid;
  logic                  out_tready = 1'b1;
  wire  [OUT_W-1:0]      out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = hmtri_pkg::REG_GRID_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block's registers and vertex store
  logic [DIM_W-1:0]   grid_columns_q = hmtri_pkg::COLUMNS_RST;
  logic [DIM_W-1:0]   grid_rows_q = hmtri_pkg::ROWS_RST;
  logic [INV_W-1:0]   inv_spacing_q = hmtri_pkg::INV_RST;
  logic signed [15:0] vertex_height [GRID_MAX*GRID_MAX];
  bit                 vertex_written [GRID_MAX*GRID_MAX];

  logic [OUT_W-1:0] pending_heights [$];
  logic [OUT_W-1:0] expected_height;
  int               mismatch_count = 0;
  int               items_accepted = 0;
  int               stall_left = 0;
  int               idle_cycles = 0;
  bit               in_idle_en = 1'b1;
  bit               out_idle_en = 1'b1;
  directed_step_t   directed_steps [DIRECTED_STEPS];

  heightmap_triangle_height_query u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // low bit up: row, column, height, position_x, position_z, pad
    .in_tuser   (in_tuser),   // opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // terrain_height
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_dim(input logic [DIM_W-1:0] v);
    if (v < 2) return 2;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  // Cell that a position falls in, and the unclamped Q.8 offsets inside it
  function automatic void locate_cell(input logic signed [POS_W-1:0] px, pz,
                                      output longint row, col, dx, dz);
    longint cols, rows, inv, pxl, pzl, cx, cz;
    cols = clamp_dim(grid_columns_q);
    rows = clamp_dim(grid_rows_q);
    inv  = inv_spacing_q;
    pxl  = px;
    pzl  = pz;
    cx   = (cols - 1) * 128 + ((pxl * inv) >>> 16);
    cz   = (rows - 1) * 128 + ((-(pzl * inv)) >>> 16);
    col  = cx >>> 8;
    row  = cz >>> 8;
    if (col < 0) col = 0;
    if (row < 0) row = 0;
    if (col > cols - 2) col = cols - 2;
    if (row > rows - 2) row = rows - 2;
    dx = cx - col * 256;
    dz = cz - row * 256;
  endfunction

  function automatic logic [OUT_W-1:0] predict_height(input logic [POS_W-1:0] px, pz);
    longint row, col, dx, dz, a, b, c, d, h;
    locate_cell(px, pz, row, col, dx, dz);
    a = vertex_height[row * GRID_MAX + col];
    b = vertex_height[row * GRID_MAX + col + 1];
    c = vertex_height[(row + 1) * GRID_MAX + col];
    d = vertex_height[(row + 1) * GRID_MAX + col + 1];
    if (dx + dz < 256) h = a * 256 + (b - a) * dx + (c - a) * dz;
    else h = d * 256 + (c - d) * (256 - dx) + (b - d) * (256 - dz);
    if (h > 8388607) h = 8388607;
    else if (h < -8388608) h = -8388608;
    return h[OUT_W-1:0];
  endfunction

  // Position that lands on the grid or just past its edge along one axis
  function automatic logic [POS_W-1:0] near_position(input logic [DIM_W-1:0] dim_reg);
    longint span, target, inv, p;
    span   = (clamp_dim(dim_reg) - 1) * 128;
    target = longint'($urandom_range(0, 32'(2 * span + 1024))) - span - 512;
    inv    = inv_spacing_q;
    if (inv == 0) return POS_W'($urandom);
    p = (target * 65536) / inv;
    if (p > 8388607) p = 8388607;
    else if (p < -8388608) p = -8388608;
    return p[POS_W-1:0];
  endfunction

  function automatic directed_step_t step_write(input int r, c, input logic [15:0] h);
    directed_step_t s;
    s = '{kind: STEP_WRITE, row: 7'(r), column: 7'(c), height: h, px: '0, pz: '0,
          reg_index: hmtri_pkg::REG_GRID_COLUMNS, reg_value: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic directed_step_t step_query(input logic [POS_W-1:0] px, pz,
                                                input bit typed, input logic [OUT_W-1:0] want);
    directed_step_t s;
    s = '{kind: STEP_QUERY, row: '0, column: '0, height: '0, px: px, pz: pz,
          reg_index: hmtri_pkg::REG_GRID_COLUMNS, reg_value: '0, typed: typed, want: want};
    return s;
  endfunction

  function automatic directed_step_t step_config(input logic [CFG_IDX_W-1:0] index,
                                                 input logic [CFG_DATA_W-1:0] value);
    directed_step_t s;
    s = '{kind: STEP_CONFIG, row: '0, column: '0, height: '0, px: '0, pz: '0,
          reg_index: index, reg_value: value, typed: 1'b0, want: '0};
    return s;
  endfunction

  // Offer one transaction, wait for it to be taken, then update the mirror
  task automatic push_item(input logic op, input logic [IDX_W-1:0] row, column,
                           input logic [15:0] height, input logic [POS_W-1:0] px, pz,
                           input bit typed, input logic [OUT_W-1:0] want);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, pz, px, height, column, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_accepted++;
    if (op == hmtri_pkg::OP_WRITE) begin
      vertex_height[row * GRID_MAX + column] = height;
      vertex_written[row * GRID_MAX + column] = 1'b1;
    end else begin
      pending_heights.push_back(typed ? want : predict_height(px, pz));
    end
  endtask

  // Load any corner the query would read that has never been written, then query
  task automatic query_at(input logic [POS_W-1:0] px, pz,
                          input bit typed, input logic [OUT_W-1:0] want);
    longint row, col, dx, dz, r, c;
    locate_cell(px, pz, row, col, dx, dz);
    for (int i = 0; i < 4; i++) begin
      r = row + i / 2;
      c = col + i % 2;
      if (!vertex_written[r * GRID_MAX + c])
        push_item(hmtri_pkg::OP_WRITE, 7'(r), 7'(c), 16'($urandom), 24'($urandom),
                  24'($urandom), 1'b0, '0);
    end
    push_item(hmtri_pkg::OP_QUERY, 7'($urandom), 7'($urandom), 16'($urandom), px, pz,
              typed, want);
  endtask

  // Hold the input until every result is back and the pipeline has emptied
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (index)
      hmtri_pkg::REG_GRID_COLUMNS: grid_columns_q = value[DIM_W-1:0];
      hmtri_pkg::REG_GRID_ROWS:    grid_rows_q = value[DIM_W-1:0];
      hmtri_pkg::REG_INV_SPACING:  inv_spacing_q = value[INV_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: check each transaction and stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected terrain height: expected none, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        expected_height = pending_heights.pop_front();
        if (out_tdata !== expected_height) begin
          $display("%0t: terrain height mismatch: expected %h, actual %h",
                   $time, expected_height, out_tdata);
          mismatch_count++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (out_idle_en && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WATCHDOG_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] cols_v, rows_v, inv_v;
    int phase_end;
    int r, c;

    directed_steps = '{
      step_write(63, 63, 16'd100),
      step_write(63, 64, 16'd300),
      step_write(64, 63, 16'd100),
      step_write(64, 64, 16'd100),
      step_query(24'h000000, 24'h000000, 1'b1, 24'h00C800),
      // exactly on a vertex
      step_query(24'hFFFF80, 24'h000080, 1'b1, 24'h006400),
      step_query(24'hFFFFC0, 24'h000040, 1'b0, '0),
      step_write(63, 126, 16'h0000),
      step_write(63, 127, 16'h7FFF),
      step_write(64, 126, 16'h8000),
      step_write(64, 127, 16'h7FFF),
      // far right edge: extrapolation saturates high
      step_query(24'h7FFFFF, 24'h000000, 1'b1, 24'h7FFFFF),
      step_write(63, 0, 16'h0000),
      step_write(63, 1, 16'h7FFF),
      step_write(64, 0, 16'h0000),
      step_write(64, 1, 16'h8000),
      // far left edge: extrapolation saturates low
      step_query(24'h800000, 24'h000000, 1'b1, 24'h800000),
      step_config(REG_UNMAPPED, 24'hFFFFFF),
      step_query(24'h000000, 24'h000000, 1'b1, 24'h00C800),
      step_config(hmtri_pkg::REG_GRID_COLUMNS, 24'h000000),
      step_config(hmtri_pkg::REG_GRID_ROWS, 24'hFFFFFF),
      // zero spacing reciprocal maps everything to the center
      step_config(hmtri_pkg::REG_INV_SPACING, 24'h000000),
      step_query(24'h7FFFFF, 24'h800000, 1'b0, '0),
      step_config(hmtri_pkg::REG_INV_SPACING, 24'hFFFFFF),
      step_query(24'h000100, 24'hFFFF00, 1'b0, '0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        STEP_WRITE:
          push_item(hmtri_pkg::OP_WRITE, directed_steps[i].row, directed_steps[i].column,
                    directed_steps[i].height, 24'($urandom), 24'($urandom), 1'b0, '0);
        STEP_QUERY:
          query_at(directed_steps[i].px, directed_steps[i].pz, directed_steps[i].typed,
                   directed_steps[i].want);
        default:
          write_register(directed_steps[i].reg_index, directed_steps[i].reg_value);
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          cols_v = CFG_DATA_W'(hmtri_pkg::COLUMNS_RST);
          rows_v = CFG_DATA_W'(hmtri_pkg::ROWS_RST);
          inv_v  = CFG_DATA_W'(hmtri_pkg::INV_RST);
        end
        1: begin cols_v = 24'd2; rows_v = 24'd2; inv_v = 24'hFFFFFF; end
        2: begin cols_v = 24'd1; rows_v = 24'd200; inv_v = 24'd1; end
        3: begin
          cols_v = CFG_DATA_W'($urandom_range(2, 16));
          rows_v = CFG_DATA_W'($urandom_range(2, 16));
          inv_v  = CFG_DATA_W'($urandom_range(1, 24'h0FFFFF));
        end
        4: begin
          cols_v = 24'd128;
          rows_v = 24'd3;
          inv_v  = CFG_DATA_W'($urandom_range(24'h4000, 24'h40000));
        end
        5: begin
          cols_v = CFG_DATA_W'($urandom);
          rows_v = CFG_DATA_W'($urandom);
          inv_v  = CFG_DATA_W'($urandom);
        end
        default: begin
          cols_v = CFG_DATA_W'($urandom_range(2, 24));
          rows_v = CFG_DATA_W'($urandom_range(2, 24));
          inv_v  = CFG_DATA_W'($urandom_range(24'h8000, 24'h30000));
        end
      endcase
      write_register(hmtri_pkg::REG_GRID_COLUMNS, cols_v);
      write_register(hmtri_pkg::REG_GRID_ROWS, rows_v);
      write_register(hmtri_pkg::REG_INV_SPACING, inv_v);
      // no idling in the last phase
      in_idle_en  = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      out_idle_en = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      phase_end = items_accepted + PHASE_ITEMS;
      while (items_accepted < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          r = $urandom_range(0, 1) ? $urandom_range(0, 32'(clamp_dim(grid_rows_q) - 1))
                                   : $urandom_range(0, GRID_MAX - 1);
          c = $urandom_range(0, 1) ? $urandom_range(0, 32'(clamp_dim(grid_columns_q) - 1))
                                   : $urandom_range(0, GRID_MAX - 1);
          push_item(hmtri_pkg::OP_WRITE, 7'(r), 7'(c), 16'($urandom), 24'($urandom),
                    24'($urandom), 1'b0, '0);
        end else begin
          query_at(($urandom_range(0, 4) == 0) ? 24'($urandom) : near_position(grid_columns_q),
                   ($urandom_range(0, 4) == 0) ? 24'($urandom) : near_position(grid_rows_q),
                   1'b0, '0);
        end
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
